### design/rccf_pkg.sv
// Shared widths, color codes and the color wheel table for the RGB color cycle fader.
package rccf_pkg;

	localparam int LEVEL_W  = 15;
	localparam int STEP_W   = 15;
	localparam int OUT_W    = 8;
	localparam int COLOR_W  = 3;
	localparam int CH_N     = 3;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [COLOR_W-1:0] COLOR_RED     = 3'd0;
	localparam logic [COLOR_W-1:0] COLOR_YELLOW  = 3'd1;
	localparam logic [COLOR_W-1:0] COLOR_GREEN   = 3'd2;
	localparam logic [COLOR_W-1:0] COLOR_CYAN    = 3'd3;
	localparam logic [COLOR_W-1:0] COLOR_BLUE    = 3'd4;
	localparam logic [COLOR_W-1:0] COLOR_MAGENTA = 3'd5;
	localparam logic [COLOR_W-1:0] COLOR_LAST    = COLOR_MAGENTA;

	localparam logic [STEP_W-1:0] STEP_RESET = 15'd510;

	localparam logic APB_REG_STEP = 1'b0;

	// floor(x / 100) == (x * 5243) >> 19 for every 15-bit x
	localparam int DIV_MULT_W = 13;
	localparam logic [DIV_MULT_W-1:0] DIV_MULT = 13'd5243;
	localparam int DIV_SHIFT  = 19;
	localparam int QUOT_W     = LEVEL_W + DIV_MULT_W - DIV_SHIFT;

	// bit 0 red, bit 1 green, bit 2 blue
	function automatic logic [CH_N-1:0] wheel_mask(input logic [COLOR_W-1:0] color);
		logic [CH_N-1:0] m;
		case (color)
			COLOR_RED:     m = 3'b001;
			COLOR_YELLOW:  m = 3'b011;
			COLOR_GREEN:   m = 3'b010;
			COLOR_CYAN:    m = 3'b110;
			COLOR_BLUE:    m = 3'b100;
			COLOR_MAGENTA: m = 3'b101;
			default:       m = 3'b001;
		endcase
		return m;
	endfunction

endpackage

### design/rccf_if.sv
// Valid/ready channel interfaces for tick items and color result items.
interface rccf_tick_if
	import rccf_pkg::*;
();
	logic valid;
	logic ready;
	logic tick;

	modport source (output valid, output tick, input ready);
	modport sink   (input valid, input tick, output ready);
endinterface

interface rccf_color_if
	import rccf_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [OUT_W-1:0]   red_out;
	logic [OUT_W-1:0]   green_out;
	logic [OUT_W-1:0]   blue_out;
	logic               falling;
	logic [COLOR_W-1:0] target_color;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output falling, output target_color, input ready);
	modport sink   (input valid, input red_out, input green_out, input blue_out,
		input falling, input target_color, output ready);
endinterface

### design/rgb_color_cycle_fader.sv
// Top level of the RGB color cycle fader: fade state, result pipeline and APB step register.
//
// Usage:
//   tick_chan carries one item per update period; an item with tick high
//   advances the fade, an item with tick low only reports the current state.
//   Every accepted item yields exactly one item on color_chan holding the
//   red, green and blue levels divided by 100, the falling flag and the
//   current target color.
//   A result passes stage 1 and then the output register: the fade state
//   and stage 1 update at acceptance, and the divide-by-100 multiplier feeds
//   the output register from stage 1. Throughput is one item per cycle
//   while color_chan does not stall; when it stalls, the pipeline holds up
//   to two results and tick_chan.ready drops only once both stages are occupied.
//   Reset clears levels, flags and the target (red) and sets step to 510.
//   The step register lies at APB byte address 0; write it only while the
//   block is idle. pready is always high.
module rgb_color_cycle_fader
	import rccf_pkg::*;
#(
	parameter int LEVEL_MAX = 25500
) (
	input  logic                clk,
	input  logic                arst_n,
	rccf_tick_if.sink           tick_chan,
	rccf_color_if.source        color_chan,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready
);

	localparam logic [LEVEL_W-1:0] LVL_MAX = LEVEL_W'(LEVEL_MAX);

	logic [STEP_W-1:0]  step_q;
	logic [LEVEL_W-1:0] lvl_q [CH_N];
	logic [CH_N-1:0]    rch_q;
	logic               all_q;
	logic [COLOR_W-1:0] tgt_q;

	logic [LEVEL_W-1:0] lvl_n [CH_N];
	logic [CH_N-1:0]    rch_n;
	logic               all_n;
	logic [COLOR_W-1:0] tgt_n;

	logic [LEVEL_W-1:0] lvl_s1 [CH_N];
	logic               all_s1;
	logic [COLOR_W-1:0] tgt_s1;
	logic               vld_s1;

	logic               out_vld_q;
	logic               out_free;
	logic               s1_move;
	logic               in_acc;

	logic [COLOR_W-1:0] color;
	logic [CH_N-1:0]    mask;
	logic [LEVEL_W-1:0] tgt_lvl [CH_N];
	logic [LEVEL_W:0]   sum_w   [CH_N];

	logic [LEVEL_W+DIV_MULT_W-1:0] prod [CH_N];
	logic [QUOT_W-1:0]             quot [CH_N];
	logic [OUT_W-1:0]              scl  [CH_N];

	// APB step register
	assign pready = 1'b1;
	assign prdata = APB_DW'(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == APB_REG_STEP)) begin
			step_q <= pwdata[STEP_W-1:0];
		end
	end

	// handshake
	assign out_free        = !out_vld_q || color_chan.ready;
	assign s1_move         = vld_s1 && out_free;
	assign tick_chan.ready = !vld_s1 || out_free;
	assign in_acc          = tick_chan.valid && tick_chan.ready;

	// fade update
	always_comb begin
		lvl_n = lvl_q;
		rch_n = rch_q;
		all_n = all_q;
		tgt_n = tgt_q;
		color = (tgt_q <= COLOR_LAST) ? tgt_q : COLOR_RED;
		mask  = wheel_mask(color);
		for (int i = 0; i < CH_N; i++) begin
			tgt_lvl[i] = mask[i] ? LVL_MAX : '0;
			sum_w[i]   = {1'b0, lvl_q[i]} + {1'b0, step_q};
		end
		if (tick_chan.tick) begin
			if (!all_q) begin
				for (int i = 0; i < CH_N; i++) begin
					if (lvl_q[i] <= tgt_lvl[i]) begin
						if (sum_w[i] >= {1'b0, tgt_lvl[i]}) begin
							lvl_n[i] = tgt_lvl[i];
							rch_n[i] = 1'b1;
						end else begin
							lvl_n[i] = sum_w[i][LEVEL_W-1:0];
						end
					end
				end
				all_n = &rch_n;
			end
			if (all_n) begin
				for (int i = 0; i < CH_N; i++) begin
					if (lvl_n[i] <= step_q) begin
						lvl_n[i] = '0;
						rch_n[i] = 1'b0;
					end else begin
						lvl_n[i] = lvl_n[i] - step_q;
					end
				end
				all_n = |rch_n;
				if (!all_n) begin
					tgt_n = (color == COLOR_LAST) ? COLOR_RED : color + COLOR_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CH_N; i++) begin
				lvl_q[i] <= '0;
			end
			rch_q <= '0;
			all_q <= 1'b0;
			tgt_q <= COLOR_RED;
		end else if (in_acc) begin
			lvl_q <= lvl_n;
			rch_q <= rch_n;
			all_q <= all_n;
			tgt_q <= tgt_n;
		end
	end

	// stage 1: updated state snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_acc || (vld_s1 && !s1_move);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			lvl_s1 <= lvl_n;
			all_s1 <= all_n;
			tgt_s1 <= tgt_n;
		end
	end

	// divide by 100 and saturate
	always_comb begin
		for (int i = 0; i < CH_N; i++) begin
			prod[i] = lvl_s1[i] * DIV_MULT;
			quot[i] = prod[i][LEVEL_W+DIV_MULT_W-1:DIV_SHIFT];
			scl[i]  = (quot[i] > QUOT_W'(255)) ? {OUT_W{1'b1}} : quot[i][OUT_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= s1_move || (out_vld_q && !color_chan.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			color_chan.red_out      <= scl[0];
			color_chan.green_out    <= scl[1];
			color_chan.blue_out     <= scl[2];
			color_chan.falling      <= all_s1;
			color_chan.target_color <= tgt_s1;
		end
	end

	assign color_chan.valid = out_vld_q;

	// checks
	a_level_max: assert property (@(posedge clk) disable iff (!arst_n)
		(lvl_q[0] <= LVL_MAX) && (lvl_q[1] <= LVL_MAX) && (lvl_q[2] <= LVL_MAX))
		else $error("channel level above maximum");

	a_target_range: assert property (@(posedge clk) disable iff (!arst_n)
		tgt_q <= COLOR_LAST)
		else $error("target color out of range");

	a_flag_falling: assert property (@(posedge clk) disable iff (!arst_n)
		all_q |-> (|rch_q))
		else $error("falling with no reached channel");

	a_flag_rising: assert property (@(posedge clk) disable iff (!arst_n)
		!all_q |-> !(&rch_q))
		else $error("rising with all channels reached");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !tick_chan.tick) |=> ($stable(rch_q) && $stable(all_q) && $stable(tgt_q)))
		else $error("state moved on an item without tick");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !s1_move) |=> (vld_s1 && $stable(all_s1) && $stable(tgt_s1)))
		else $error("stage 1 result lost while stalled");

endmodule

### sim/rccf_fade_checker.sv
// Checker for the RGB color cycle fader: follows the fade from accepted ticks and step writes, compares each result item.
module rccf_fade_checker
	import rccf_pkg::*;
#(
	parameter int LEVEL_TOP = 25500
) (
	input  logic              clk,
	input  logic              arst_n,
	rccf_tick_if              tick_mon,
	rccf_color_if             color_mon,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	input  logic              pready,
	output int                fail_cnt,
	output int                outstanding,
	output int                checked,
	output int                laps
);

	localparam int CH_RED       = 0;
	localparam int CH_GREEN     = 1;
	localparam int CH_BLUE      = 2;
	localparam int LEVEL_DIV    = 100;
	localparam int OUT_TOP      = (1 << OUT_W) - 1;
	localparam int REPORT_MAX   = 10;

	typedef struct packed {
		logic [OUT_W-1:0]   red;
		logic [OUT_W-1:0]   green;
		logic [OUT_W-1:0]   blue;
		logic               falling;
		logic [COLOR_W-1:0] color;
	} shade_t;

	int unsigned        level [CH_N];
	logic [CH_N-1:0]    reached;
	logic               fading;
	logic [COLOR_W-1:0] color;
	int unsigned        step;
	shade_t             shade_q [$];
	shade_t             want;
	shade_t             got;
	int                 fails;
	int                 seen;
	int                 wraps;

	function automatic logic lit(input logic [COLOR_W-1:0] c, input int ch);
		logic [COLOR_W-1:0] k;
		k = (c > COLOR_LAST) ? COLOR_RED : c;
		case (ch)
			CH_RED:   return k == COLOR_RED || k == COLOR_YELLOW || k == COLOR_MAGENTA;
			CH_GREEN: return k == COLOR_YELLOW || k == COLOR_GREEN || k == COLOR_CYAN;
			default:  return k == COLOR_CYAN || k == COLOR_BLUE || k == COLOR_MAGENTA;
		endcase
	endfunction

	function automatic logic [OUT_W-1:0] to_out(input int unsigned lv);
		int unsigned v;
		v = lv / LEVEL_DIV;
		if (v > OUT_TOP)
			v = OUT_TOP;
		return v[OUT_W-1:0];
	endfunction

	function automatic void advance_fade();
		int unsigned goal;
		int unsigned sum;
		if (!fading) begin
			for (int ch = 0; ch < CH_N; ch++) begin
				goal = lit(color, ch) ? LEVEL_TOP : 0;
				if (level[ch] <= goal) begin
					sum = level[ch] + step;
					if (sum >= goal) begin
						sum = goal;
						reached[ch] = 1'b1;
					end
					level[ch] = sum;
				end
			end
			fading = &reached;
		end
		if (fading) begin
			for (int ch = 0; ch < CH_N; ch++) begin
				if (level[ch] <= step) begin
					level[ch] = 0;
					reached[ch] = 1'b0;
				end else begin
					level[ch] = level[ch] - step;
				end
			end
			fading = |reached;
			if (!fading) begin
				if (color > COLOR_LAST) begin
					color = COLOR_YELLOW;
				end else if (color == COLOR_LAST) begin
					color = COLOR_RED;
					wraps++;
				end else begin
					color = color + 1'b1;
				end
			end
		end
	endfunction

	function automatic shade_t snapshot();
		shade_t s;
		s.red     = to_out(level[CH_RED]);
		s.green   = to_out(level[CH_GREEN]);
		s.blue    = to_out(level[CH_BLUE]);
		s.falling = fading;
		s.color   = color;
		return s;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int ch = 0; ch < CH_N; ch++)
				level[ch] = 0;
			reached = '0;
			fading  = 1'b0;
			color   = COLOR_RED;
			step    = STEP_RESET;
			shade_q.delete();
			fails = 0;
			seen  = 0;
			wraps = 0;
			fail_cnt    <= 0;
			outstanding <= 0;
			checked     <= 0;
			laps        <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[APB_AW-1:2] == APB_REG_STEP)
				step = pwdata[STEP_W-1:0];
			if (tick_mon.valid && tick_mon.ready) begin
				if (tick_mon.tick)
					advance_fade();
				shade_q.push_back(snapshot());
			end
			if (color_mon.valid && color_mon.ready) begin
				got.red     = color_mon.red_out;
				got.green   = color_mon.green_out;
				got.blue    = color_mon.blue_out;
				got.falling = color_mon.falling;
				got.color   = color_mon.target_color;
				if (shade_q.size() == 0) begin
					fails++;
					if (fails <= REPORT_MAX)
						$display("unexpected result item: r=%0d g=%0d b=%0d falling=%0d color=%0d",
							got.red, got.green, got.blue, got.falling, got.color);
				end else begin
					want = shade_q.pop_front();
					if (want.red != got.red || want.green != got.green || want.blue != got.blue ||
						want.falling != got.falling || want.color != got.color) begin
						fails++;
						if (fails <= REPORT_MAX)
							$display("item %0d mismatch: expected r=%0d g=%0d b=%0d falling=%0d color=%0d, got r=%0d g=%0d b=%0d falling=%0d color=%0d",
								seen, want.red, want.green, want.blue, want.falling, want.color,
								got.red, got.green, got.blue, got.falling, got.color);
					end
				end
				seen++;
			end
			fail_cnt    <= fails;
			outstanding <= shade_q.size();
			checked     <= seen;
			laps        <= wraps;
		end
	end

endmodule

### sim/rgb_color_cycle_fader_tb.sv
// Testbench top for the RGB color cycle fader: clock, reset, tick and step stimulus, watchdog and verdict.
module rgb_color_cycle_fader_tb;
	import rccf_pkg::*;

	localparam int LEVEL_TOP      = 25500;
	localparam int ITEMS_TOTAL    = 800;
	localparam int TAIL_ITEMS     = 120;
	localparam int WATCHDOG_LIMIT = 200;
	localparam int STEP_TOP       = (1 << STEP_W) - 1;
	localparam logic [APB_AW-1:0] STEP_ADDR  = {APB_REG_STEP, 2'b00};
	localparam logic [APB_AW-1:0] SPARE_ADDR = {~APB_REG_STEP, 2'b00};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              pauses_on;
	int                fail_cnt;
	int                outstanding;
	int                checked;
	int                laps;
	int                ticks_sent = 0;
	int                step_writes = 0;
	int                quiet = 0;
	int                hold_left = 0;
	int                n;

	rccf_tick_if  tick_if ();
	rccf_color_if color_if ();

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	rgb_color_cycle_fader #(
		.LEVEL_MAX (LEVEL_TOP)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_chan  (tick_if),
		.color_chan (color_if),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	rccf_fade_checker #(
		.LEVEL_TOP (LEVEL_TOP)
	) u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_mon    (tick_if),
		.color_mon   (color_if),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.fail_cnt    (fail_cnt),
		.outstanding (outstanding),
		.checked     (checked),
		.laps        (laps)
	);

	// stall the result side in short bursts
	initial begin
		color_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				color_if.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				color_if.ready <= 1'b0;
			end else if (pauses_on && $urandom_range(0, 3) == 0) begin
				hold_left = $urandom_range(0, 2);
				color_if.ready <= 1'b0;
			end else begin
				color_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (tick_if.valid && tick_if.ready) || (color_if.valid && color_if.ready) || psel)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", quiet);
			$display("FAIL");
			$finish;
		end
	end

	task automatic push_tick(input logic t);
		if (pauses_on && $urandom_range(0, 3) == 0) begin
			tick_if.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		tick_if.valid <= 1'b1;
		tick_if.tick  <= t;
		do @(posedge clk); while (!tick_if.ready);
		ticks_sent++;
	endtask

	task automatic settle();
		tick_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		if (addr == STEP_ADDR)
			step_writes++;
	endtask

	function automatic logic [APB_DW-1:0] step_word(input int unsigned s);
		logic [APB_DW-1:0] w;
		w = $urandom;
		w[STEP_W-1:0] = s[STEP_W-1:0];
		return w;
	endfunction

	function automatic int unsigned pick_step();
		case ($urandom_range(0, 9))
			0:       return 1;
			1:       return LEVEL_TOP;
			2:       return STEP_TOP;
			3:       return $urandom_range(1, 200);
			default: return $urandom_range(300, 13000);
		endcase
	endfunction

	initial begin
		tick_if.valid <= 1'b0;
		tick_if.tick  <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		pauses_on     <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_tick(1'b0);
		push_tick(1'b1);
		push_tick(1'b1);
		push_tick(1'b0);
		settle();
		write_reg(STEP_ADDR, '1);
		repeat (13) push_tick(1'b1);
		settle();
		write_reg(SPARE_ADDR, $urandom);
		write_reg(STEP_ADDR, step_word(0));
		repeat (3) push_tick(1'b1);
		settle();
		write_reg(STEP_ADDR, step_word(LEVEL_TOP));
		repeat (3) push_tick(1'b1);
		settle();
		write_reg(STEP_ADDR, step_word(1));
		repeat (2) push_tick(1'b1);

		while (ticks_sent < ITEMS_TOTAL - TAIL_ITEMS) begin
			settle();
			if ($urandom_range(0, 7) == 0)
				write_reg(SPARE_ADDR, $urandom);
			write_reg(STEP_ADDR, step_word(pick_step()));
			pauses_on <= ($urandom_range(0, 3) != 0);
			n = $urandom_range(40, 120);
			repeat (n) push_tick($urandom_range(0, 9) != 0);
		end

		settle();
		write_reg(STEP_ADDR, step_word(pick_step()));
		pauses_on <= 1'b0;
		repeat (TAIL_ITEMS) push_tick($urandom_range(0, 9) != 0);
		settle();
		repeat (4) @(posedge clk);

		$display("%0d ticks sent under %0d step settings, %0d result items checked",
			ticks_sent, step_writes, checked);
		$display("target wheel wrapped from magenta to red %0d times, %0d mismatches",
			laps, fail_cnt);
		if (fail_cnt == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### files.f
design/rccf_pkg.sv
design/rccf_if.sv
design/rgb_color_cycle_fader.sv
sim/rccf_fade_checker.sv
sim/rgb_color_cycle_fader_tb.sv
